// ===== rtl/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, register codes, reset values and the CORDIC angle table for
// the ball range and bearing pipeline.
// ----------------------------------------------------------------------------
package brb_pkg;

  // Item and register field widths
  localparam int IN_W      = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int ANG_W     = 15;
  localparam int RANGE_W   = 32;

  // Datapath widths
  localparam int D_W        = IN_W + 1;          // signed column offset
  localparam int SQ_W       = 2 * IN_W;          // one square
  localparam int SUM_W      = SQ_W + 1;          // d^2 + fx^2
  localparam int SQRT_SHIFT = 16;                // radicand is sum * 2^16
  localparam int ROOT_W     = (SUM_W + SQRT_SHIFT + 1) / 2;
  localparam int PROD_W     = IN_W + ROOT_W;     // R * root
  localparam int DIV_SHIFT  = 8;                 // divisor is r * 2^8
  localparam int NUM_W      = PROD_W - DIV_SHIFT;

  // CORDIC
  localparam int CORDIC_STEPS    = 20;
  localparam int CORDIC_PRESHIFT = 12;
  localparam int CORDIC_W        = 32;
  localparam int Z_W             = 23;
  localparam int ATAN_W          = 20;
  localparam int ANG_DROP        = 7;            // Q.20 to Q3.13
  localparam int HALF_PI_Q13     = 12868;
  localparam int MIN_RADIUS_Q4   = 160;

  localparam logic [ATAN_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
    20'd16383,  20'd8192,   20'd4096,   20'd2048,   20'd1024,  20'd512,
    20'd256,    20'd128,    20'd64,     20'd32,     20'd16,    20'd8,
    20'd4,      20'd2
  };

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL  = 3'd0,
    REG_PRINC  = 3'd1,
    REG_RADIUS = 3'd2,
    REG_BMIN   = 3'd3,
    REG_BMAX   = 3'd4,
    REG_WIN_EN = 3'd5
  } cfg_reg_t;

  localparam logic [IN_W-1:0]         RST_FOCAL  = 16'd8000;
  localparam logic [IN_W-1:0]         RST_PRINC  = 16'd5120;
  localparam logic [IN_W-1:0]         RST_RADIUS = 16'd2621;
  localparam logic signed [ANG_W-1:0] RST_BMIN   = -15'sd12868;
  localparam logic signed [ANG_W-1:0] RST_BMAX   = 15'sd12868;

endpackage

// ===== rtl/brb_in_if.sv =====
// ----------------------------------------------------------------------------
// brb_in_if
// Detected circle channel: centre column and radius, valid/ready.
// ----------------------------------------------------------------------------
interface brb_in_if;
  logic                      valid;
  logic                      ready;
  logic [brb_pkg::IN_W-1:0]  center_col;
  logic [brb_pkg::IN_W-1:0]  radius_px;

  modport source (output valid, output center_col, output radius_px, input ready);
  modport sink   (input valid, input center_col, input radius_px, output ready);
endinterface

// ===== rtl/brb_out_if.sv =====
// ----------------------------------------------------------------------------
// brb_out_if
// Result channel: range, bearing and status, valid/ready.
// ----------------------------------------------------------------------------
interface brb_out_if;
  logic                             valid;
  logic                             ready;
  logic [brb_pkg::RANGE_W-1:0]      range_m;
  logic signed [brb_pkg::ANG_W-1:0] bearing_rad;
  logic                             status_ok;

  modport source (output valid, output range_m, output bearing_rad, output status_ok,
                  input ready);
  modport sink   (input valid, input range_m, input bearing_rad, input status_ok,
                  output ready);
endinterface

// ===== rtl/brb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// brb_cfg_if
// Register write channel: index and data, valid/ready.
// ----------------------------------------------------------------------------
interface brb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [brb_pkg::CFG_IDX_W-1:0] index;
  logic [brb_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/brb_isqrt.sv =====
// ----------------------------------------------------------------------------
// brb_isqrt
// Pipelined integer square root of sum * 2^16, one root bit per stage.
// ----------------------------------------------------------------------------
module brb_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [brb_pkg::SUM_W-1:0]    sum,
  input  logic [SIDE_W-1:0]            side_in,
  output logic [brb_pkg::ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]            side_out
);
  localparam int N     = brb_pkg::ROOT_W;
  localparam int RAD_W = 2 * N;
  localparam int REM_W = N + 2;
  localparam int PAD_W = RAD_W - brb_pkg::SUM_W - brb_pkg::SQRT_SHIFT;

  logic [RAD_W-1:0]  rad_r  [1:N];
  logic [REM_W-1:0]  rem_r  [1:N];
  logic [N-1:0]      root_r [1:N];
  logic [SIDE_W-1:0] side_r [1:N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [N-1:0]      root_i;
    logic [SIDE_W-1:0] side_i;
    logic [REM_W+1:0]  tst;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [N-1:0]      root_nxt;

    if (j == 0) begin : g_first
      assign rad_i  = {{PAD_W{1'b0}}, sum, {brb_pkg::SQRT_SHIFT{1'b0}}};
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rad_i  = rad_r[j];
      assign rem_i  = rem_r[j];
      assign root_i = root_r[j];
      assign side_i = side_r[j];
    end

    always_comb begin
      tst   = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({root_i, 2'b01});
      if (tst >= trial) begin
        rem_nxt  = REM_W'(tst - trial);
        root_nxt = {root_i[N-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(tst);
        root_nxt = {root_i[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j+1]  <= {rad_i[RAD_W-3:0], 2'b00};
        rem_r[j+1]  <= rem_nxt;
        root_r[j+1] <= root_nxt;
        side_r[j+1] <= side_i;
      end
    end
  end

  assign root     = root_r[N];
  assign side_out = side_r[N];
endmodule

// ===== rtl/brb_div.sv =====
// ----------------------------------------------------------------------------
// brb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module brb_div #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [brb_pkg::NUM_W-1:0]   num,
  input  logic [brb_pkg::IN_W-1:0]    den,
  input  logic [SIDE_W-1:0]           side_in,
  output logic [brb_pkg::NUM_W-1:0]   quo,
  output logic [SIDE_W-1:0]           side_out
);
  localparam int N   = brb_pkg::NUM_W;
  localparam int DW  = brb_pkg::IN_W;

  logic [N-1:0]      num_r  [1:N];
  logic [DW-1:0]     den_r  [1:N];
  logic [DW-1:0]     rem_r  [1:N];
  logic [N-1:0]      quo_r  [1:N];
  logic [SIDE_W-1:0] side_r [1:N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [N-1:0]      num_i;
    logic [DW-1:0]     den_i;
    logic [DW-1:0]     rem_i;
    logic [N-1:0]      quo_i;
    logic [SIDE_W-1:0] side_i;
    logic [DW:0]       tst;
    logic [DW-1:0]     rem_nxt;
    logic              bit_nxt;

    if (j == 0) begin : g_first
      assign num_i  = num;
      assign den_i  = den;
      assign rem_i  = '0;
      assign quo_i  = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign num_i  = num_r[j];
      assign den_i  = den_r[j];
      assign rem_i  = rem_r[j];
      assign quo_i  = quo_r[j];
      assign side_i = side_r[j];
    end

    always_comb begin
      tst = {rem_i, num_i[N-1]};
      if (tst >= {1'b0, den_i}) begin
        rem_nxt = DW'(tst - {1'b0, den_i});
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = DW'(tst);
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[j+1]  <= {num_i[N-2:0], 1'b0};
        den_r[j+1]  <= den_i;
        rem_r[j+1]  <= rem_nxt;
        quo_r[j+1]  <= {quo_i[N-2:0], bit_nxt};
        side_r[j+1] <= side_i;
      end
    end
  end

  assign quo      = quo_r[N];
  assign side_out = side_r[N];
endmodule

// ===== rtl/ball_range_and_bearing.sv =====
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output register. The 25-stage square root and the 33-stage
// divider run in series.
// Reset (rst_n low, synchronous): pipeline empty, registers at defaults.
// ----------------------------------------------------------------------------
// ball_range_and_bearing
// Range and bearing of a detected ball from its image circle (pinhole model).
// ----------------------------------------------------------------------------
module ball_range_and_bearing (
  input  logic            clk,
  input  logic            rst_n,
  brb_in_if.sink          in_item,
  brb_out_if.source       out_item,
  brb_cfg_if.sink         cfg_wr
);
  localparam int IW   = brb_pkg::IN_W;
  localparam int AW   = brb_pkg::ANG_W;
  localparam int CW   = brb_pkg::CORDIC_W;
  localparam int ZW   = brb_pkg::Z_W;
  localparam int NS   = brb_pkg::CORDIC_STEPS;
  localparam int PRE  = brb_pkg::CORDIC_PRESHIFT;
  localparam int DW   = brb_pkg::D_W;
  localparam int LAT  = 3 + brb_pkg::ROOT_W + 1 + brb_pkg::NUM_W + 1;
  localparam int BRG_DLY = brb_pkg::ROOT_W - NS - 2;   // stages from clamp to multiply
  localparam int SQ_SIDE = 1 + IW;
  localparam int DV_SIDE = 1 + AW + 1;

  localparam logic signed [ZW-1:0] HALF_Z = ZW'(brb_pkg::HALF_PI_Q13);
  localparam logic signed [ZW-1:0] RND_Z  = ZW'(1 << (brb_pkg::ANG_DROP - 1));
  localparam logic signed [AW-1:0] HALF_A = AW'(brb_pkg::HALF_PI_Q13);

  // Register file
  logic [IW-1:0]        fx_r, cx_r, rb_r;
  logic signed [AW-1:0] bmin_r, bmax_r;
  logic                 win_en_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r     <= brb_pkg::RST_FOCAL;
      cx_r     <= brb_pkg::RST_PRINC;
      rb_r     <= brb_pkg::RST_RADIUS;
      bmin_r   <= brb_pkg::RST_BMIN;
      bmax_r   <= brb_pkg::RST_BMAX;
      win_en_r <= 1'b1;
    end else if (cfg_wr.valid) begin
      case (brb_pkg::cfg_reg_t'(cfg_wr.index))
        brb_pkg::REG_FOCAL:  fx_r     <= cfg_wr.data;
        brb_pkg::REG_PRINC:  cx_r     <= cfg_wr.data;
        brb_pkg::REG_RADIUS: rb_r     <= cfg_wr.data;
        brb_pkg::REG_BMIN:   bmin_r   <= cfg_wr.data[AW-1:0];
        brb_pkg::REG_BMAX:   bmax_r   <= cfg_wr.data[AW-1:0];
        brb_pkg::REG_WIN_EN: win_en_r <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage advances together
  logic [LAT-1:0] vld_r;
  logic           adv;
  logic           in_acc;

  assign adv           = !vld_r[LAT-1] || out_item.ready;
  assign in_item.ready = adv;
  assign in_acc        = in_item.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_acc};
    end
  end

  // Front: offset, squares, sum
  logic signed [DW-1:0] d1_r, d2_r, d3_r;
  logic [IW-1:0]        ad1_r, r1_r, r2_r, r3_r;
  logic [2*IW-1:0]      ad2_r, fx2_r;
  logic [brb_pkg::SUM_W-1:0] sum3_r;
  logic                 found3_r;
  logic signed [DW-1:0] d_nxt;

  assign d_nxt = $signed({1'b0, in_item.center_col}) - $signed({1'b0, cx_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r     <= d_nxt;
      ad1_r    <= d_nxt[DW-1] ? IW'(-d_nxt) : IW'(d_nxt);
      r1_r     <= in_item.radius_px;
      ad2_r    <= ad1_r * ad1_r;
      fx2_r    <= fx_r * fx_r;
      d2_r     <= d1_r;
      r2_r     <= r1_r;
      sum3_r   <= {1'b0, ad2_r} + {1'b0, fx2_r};
      d3_r     <= d2_r;
      r3_r     <= r2_r;
      found3_r <= (r2_r >= IW'(brb_pkg::MIN_RADIUS_Q4));
    end
  end

  // Range: square root, scale by R, divide by r
  logic [brb_pkg::ROOT_W-1:0] root;
  logic [SQ_SIDE-1:0]         sq_side;

  brb_isqrt #(.SIDE_W(SQ_SIDE)) u_isqrt (
    .clk      (clk),
    .en       (adv),
    .sum      (sum3_r),
    .side_in  ({found3_r, r3_r}),
    .root     (root),
    .side_out (sq_side)
  );

  // Bearing: CORDIC vectoring in parallel with the square root
  logic signed [CW-1:0] cx_s_r [0:NS];
  logic signed [CW-1:0] cy_s_r [0:NS];
  logic signed [ZW-1:0] cz_s_r [0:NS];
  logic [1:0]           cf_s_r [0:NS];   // {focal zero, offset negative}

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_s_r[0] <= CW'({fx_r, {PRE{1'b0}}});
      cy_s_r[0] <= {{(CW-DW-PRE){d3_r[DW-1]}}, d3_r, {PRE{1'b0}}};
      cz_s_r[0] <= '0;
      cf_s_r[0] <= {fx_r == '0, d3_r[DW-1]};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    assign xs  = cx_s_r[k] >>> k;
    assign ys  = cy_s_r[k] >>> k;
    assign ang = ZW'(brb_pkg::CORDIC_ATAN[k]);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy_s_r[k][CW-1]) begin
          cx_s_r[k+1] <= cx_s_r[k] + ys;
          cy_s_r[k+1] <= cy_s_r[k] - xs;
          cz_s_r[k+1] <= cz_s_r[k] + ang;
        end else begin
          cx_s_r[k+1] <= cx_s_r[k] - ys;
          cy_s_r[k+1] <= cy_s_r[k] + xs;
          cz_s_r[k+1] <= cz_s_r[k] - ang;
        end
        cf_s_r[k+1] <= cf_s_r[k];
      end
    end
  end

  // Round, clamp, window check; then hold until the divider entry
  logic signed [ZW-1:0] q_rnd;
  logic signed [AW-1:0] brg_nxt;
  logic                 ok_nxt;
  logic [AW:0]          brg_r [0:BRG_DLY];

  always_comb begin
    q_rnd = (cz_s_r[NS] + RND_Z) >>> brb_pkg::ANG_DROP;
    if (cf_s_r[NS][1]) begin
      brg_nxt = cf_s_r[NS][0] ? -HALF_A : HALF_A;
    end else if (q_rnd > HALF_Z) begin
      brg_nxt = HALF_A;
    end else if (q_rnd < -HALF_Z) begin
      brg_nxt = -HALF_A;
    end else begin
      brg_nxt = AW'(q_rnd);
    end
    ok_nxt = !(win_en_r && (brg_nxt < bmin_r || brg_nxt > bmax_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      brg_r[0] <= {brg_nxt, ok_nxt};
      for (int i = 1; i <= BRG_DLY; i++) begin
        brg_r[i] <= brg_r[i-1];
      end
    end
  end

  // Scale root by the ball radius
  logic [brb_pkg::NUM_W-1:0] num_r;
  logic [IW-1:0]             den_r;
  logic [DV_SIDE-1:0]        dv_side_r;
  logic [brb_pkg::PROD_W-1:0] prod;

  assign prod = brb_pkg::PROD_W'(rb_r) * brb_pkg::PROD_W'(root);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r     <= prod[brb_pkg::PROD_W-1:brb_pkg::DIV_SHIFT];
      den_r     <= sq_side[IW-1:0];
      dv_side_r <= {sq_side[IW], brg_r[BRG_DLY]};
    end
  end

  logic [brb_pkg::NUM_W-1:0] quo;
  logic [DV_SIDE-1:0]        dv_side;

  brb_div #(.SIDE_W(DV_SIDE)) u_div (
    .clk      (clk),
    .en       (adv),
    .num      (num_r),
    .den      (den_r),
    .side_in  (dv_side_r),
    .quo      (quo),
    .side_out (dv_side)
  );

  // Output register
  logic [brb_pkg::RANGE_W-1:0] range_r;
  logic signed [AW-1:0]        bearing_r;
  logic                        ok_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_side[DV_SIDE-1]) begin
        range_r   <= (quo[brb_pkg::NUM_W-1:brb_pkg::RANGE_W] != '0) ? '1 :
                     quo[brb_pkg::RANGE_W-1:0];
        bearing_r <= dv_side[AW:1];
        ok_r      <= dv_side[0];
      end else begin
        range_r   <= '0;
        bearing_r <= '0;
        ok_r      <= 1'b0;
      end
    end
  end

  assign out_item.valid       = vld_r[LAT-1];
  assign out_item.range_m     = range_r;
  assign out_item.bearing_rad = bearing_r;
  assign out_item.status_ok   = ok_r;

  // Checks
  a_bearing_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (bearing_r <= HALF_A) && (bearing_r >= -HALF_A))
    else $error("bearing outside half pi");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && ok_r && win_en_r) |-> (bearing_r >= bmin_r) && (bearing_r <= bmax_r))
    else $error("status set outside bearing window");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_item.valid)
    else $error("result valid after reset");

endmodule

// ===== test/brb_checker.sv =====
// ----------------------------------------------------------------------------
// brb_checker
// Watches the circle, result and register channels, predicts range, bearing
// and status per accepted item, and compares results in order.
// ----------------------------------------------------------------------------
module brb_checker (
  input  logic        clk,
  input  logic        rst_n,
  brb_in_if.sink      in_mon,
  brb_out_if.sink     out_mon,
  brb_cfg_if.sink     cfg_mon,
  output int          n_errors,
  output int          n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [brb_pkg::RANGE_W-1:0]      range_m;
    logic signed [brb_pkg::ANG_W-1:0] bearing_rad;
    logic                             status_ok;
  } fix_t;

  logic [15:0]                      fx_q, cx_q, rad_q;
  logic signed [brb_pkg::ANG_W-1:0] bmin_q, bmax_q;
  logic                             win_q;
  fix_t                             fix_q[$];

  function automatic longint fshr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned rem, root, b;
    rem = n; root = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic int atan_bearing(longint fx, longint d);
    longint x, y, z, xs, ys, q;
    x = fx * 4096; y = d * 4096; z = 0;
    for (int i = 0; i < brb_pkg::CORDIC_STEPS; i++) begin
      xs = fshr(x, i); ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(brb_pkg::CORDIC_ATAN[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(brb_pkg::CORDIC_ATAN[i]);
      end
    end
    q = fshr(z + 64, brb_pkg::ANG_DROP);
    if (q > brb_pkg::HALF_PI_Q13) q = brb_pkg::HALF_PI_Q13;
    if (q < -brb_pkg::HALF_PI_Q13) q = -brb_pkg::HALF_PI_Q13;
    return int'(q);
  endfunction

  function automatic fix_t locate_ball(logic [15:0] u, logic [15:0] r);
    fix_t f;
    longint d, bear;
    longint unsigned ad, root, rng;
    f = '0;
    if (r < brb_pkg::MIN_RADIUS_Q4) return f;
    d = longint'(u) - longint'(cx_q);
    ad = (d < 0) ? -d : d;
    root = int_sqrt((ad * ad + longint'(fx_q) * longint'(fx_q)) << 16);
    rng = (longint'(rad_q) * root) / (longint'(r) * 256);
    if (rng > 64'hFFFF_FFFF) rng = 64'hFFFF_FFFF;
    if (fx_q == 0) bear = (d < 0) ? -brb_pkg::HALF_PI_Q13 : brb_pkg::HALF_PI_Q13;
    else bear = atan_bearing(fx_q, d);
    f.range_m = rng[31:0];
    f.bearing_rad = brb_pkg::ANG_W'(bear);
    f.status_ok = !(win_q && (bear < bmin_q || bear > bmax_q));
    return f;
  endfunction

  assign n_pending = fix_q.size();

  always @(posedge clk) begin
    fix_t e;
    if (!rst_n) begin
      fx_q <= brb_pkg::RST_FOCAL; cx_q <= brb_pkg::RST_PRINC; rad_q <= brb_pkg::RST_RADIUS;
      bmin_q <= brb_pkg::RST_BMIN; bmax_q <= brb_pkg::RST_BMAX; win_q <= 1'b1;
      fix_q.delete();
      n_errors <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          brb_pkg::REG_FOCAL:  fx_q   <= cfg_mon.data;
          brb_pkg::REG_PRINC:  cx_q   <= cfg_mon.data;
          brb_pkg::REG_RADIUS: rad_q  <= cfg_mon.data;
          brb_pkg::REG_BMIN:   bmin_q <= cfg_mon.data[brb_pkg::ANG_W-1:0];
          brb_pkg::REG_BMAX:   bmax_q <= cfg_mon.data[brb_pkg::ANG_W-1:0];
          brb_pkg::REG_WIN_EN: win_q  <= cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        fix_q.push_back(locate_ball(in_mon.center_col, in_mon.radius_px));
      if (out_mon.valid && out_mon.ready) begin
        if (fix_q.size() == 0) begin
          if (n_errors < 10) $display("unexpected result at %0t", $realtime);
          n_errors <= n_errors + 1;
        end else begin
          e = fix_q.pop_front();
          if (e.range_m !== out_mon.range_m || e.bearing_rad !== out_mon.bearing_rad ||
              e.status_ok !== out_mon.status_ok) begin
            if (n_errors < 10)
              $display("mismatch: exp range %0d bearing %0d ok %0d, got %0d %0d %0d",
                       e.range_m, e.bearing_rad, e.status_ok, out_mon.range_m,
                       out_mon.bearing_rad, out_mon.status_ok);
            n_errors <= n_errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_ball_range_and_bearing.sv =====
// ----------------------------------------------------------------------------
// tb_ball_range_and_bearing
// Drives circles and register settings into the ball locator; circles get
// random gaps, results random stalls; the checker predicts and compares each.
// ----------------------------------------------------------------------------
module tb_ball_range_and_bearing;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 4000;
  // index outside the register list; the write must be ignored
  localparam logic [brb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   n_errors, n_pending, idle_cycles;
  bit   inputs_done = 1'b0;

  brb_in_if  in_ch();
  brb_out_if out_ch();
  brb_cfg_if cfg_ch();

  ball_range_and_bearing dut (.clk(clk), .rst_n(rst_n), .in_item(in_ch.sink),
                              .out_item(out_ch.source), .cfg_wr(cfg_ch.sink));
  brb_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                   .cfg_mon(cfg_ch.sink), .n_errors(n_errors), .n_pending(n_pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.center_col = '0; in_ch.radius_px = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog: count cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n || inputs_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side stalls
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) w = 0;
      out_ch.ready = 1'b0;
      repeat (w) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic write_reg(logic [brb_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1; cfg_ch.index = idx; cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_circle(logic [15:0] u, logic [15:0] r, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 18) : 0;
    if (gaps && $urandom_range(0, 3) == 0) w = 0;
    repeat (w) @(negedge clk);
    in_ch.valid = 1'b1; in_ch.center_col = u; in_ch.radius_px = r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain_all();
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_burst(int count);
    logic [15:0] r, u;
    bit burst;
    burst = 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: r = 16'($urandom_range(0, 159));
        1: r = 16'($urandom_range(160, 2000));
        2: r = 16'($urandom());
        default: r = 16'($urandom_range(160, 16000));
      endcase
      u = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 10240));
      send_circle(u, r, !burst || (i % 50 > 25));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, no-ball threshold, both sides of center
    send_circle(16'd0, 16'd159, 1'b0);
    send_circle(16'd0, 16'd160, 1'b0);
    send_circle(16'hFFFF, 16'd160, 1'b0);
    send_circle(16'd5120, 16'hFFFF, 1'b0);
    send_circle(16'hFFFF, 16'hFFFF, 1'b0);
    send_circle(16'd0, 16'd0, 1'b0);
    send_circle(16'd5120, 16'd1000, 1'b0);
    send_circle(16'd2000, 16'd500, 1'b0);
    random_burst(300);
    drain_all();

    // zero focal length, largest ball radius, narrow window
    write_reg(brb_pkg::REG_FOCAL, 16'd0);
    write_reg(brb_pkg::REG_RADIUS, 16'hFFFF);
    write_reg(brb_pkg::REG_BMIN, 16'(-2000));
    write_reg(brb_pkg::REG_BMAX, 16'd2000);
    write_reg(REG_UNUSED, 16'h1234);
    send_circle(16'd0, 16'd160, 1'b0);
    send_circle(16'hFFFF, 16'd160, 1'b0);
    send_circle(16'd5120, 16'd300, 1'b0);
    drain_all();
    write_reg(brb_pkg::REG_FOCAL, 16'd1);
    random_burst(200);
    drain_all();

    // zero ball radius, max focal, window disabled
    write_reg(brb_pkg::REG_RADIUS, 16'd0);
    write_reg(brb_pkg::REG_FOCAL, 16'hFFFF);
    write_reg(brb_pkg::REG_PRINC, 16'hFFFF);
    write_reg(brb_pkg::REG_WIN_EN, 16'd0);
    random_burst(250);
    drain_all();

    // inverted window, then random settings
    write_reg(brb_pkg::REG_PRINC, 16'd0);
    write_reg(brb_pkg::REG_RADIUS, 16'd2621);
    write_reg(brb_pkg::REG_FOCAL, 16'd4000);
    write_reg(brb_pkg::REG_WIN_EN, 16'd1);
    write_reg(brb_pkg::REG_BMIN, 16'd12868);
    write_reg(brb_pkg::REG_BMAX, 16'(-12868));
    random_burst(200);
    drain_all();

    for (int p = 0; p < 6; p++) begin
      write_reg(brb_pkg::REG_FOCAL, 16'($urandom_range(1, 65535)));
      write_reg(brb_pkg::REG_PRINC, 16'($urandom()));
      write_reg(brb_pkg::REG_RADIUS, 16'($urandom()));
      write_reg(brb_pkg::REG_BMIN, 16'($signed($urandom_range(0, 25736)) - 12868));
      write_reg(brb_pkg::REG_BMAX, 16'($signed($urandom_range(0, 25736)) - 12868));
      write_reg(brb_pkg::REG_WIN_EN, 16'($urandom_range(0, 1)));
      random_burst(150);
      drain_all();
    end

    inputs_done = 1'b1;
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
